@@ design/particle_pool_engine_assert.svh @@
// Assertion macros shared by the checker of the particle pool engine.
// Included by the checker file only.
`ifndef PARTICLE_POOL_ENGINE_ASSERT_SVH
`define PARTICLE_POOL_ENGINE_ASSERT_SVH

// implication checked at every rising clock edge outside reset
`define PPE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication checked outside reset
`define PPE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/ppe_pkg.sv @@
// Package of the particle pool engine: types, codes and constants.
// No dependencies.
`default_nettype none
package ppe_pkg;
  localparam int unsigned PoolSizeDef = 512;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_EMIT  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_DRAW  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REJECTED = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_e;

  // one queued command, already decoded by the front part
  typedef struct packed {
    cmd_e        cmd;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [23:0] vel_x;
    logic [23:0] vel_y;
    logic [23:0] gravity;
    logic [15:0] lifetime;
    logic [15:0] start_size;
    logic [23:0] color_start;
    logic [23:0] color_end;
    logic [15:0] delta_time;
    logic [8:0]  slot;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_EMIT,
    BK_TRD,
    BK_TAGE,
    BK_TMUL,
    BK_TSUM,
    BK_TVY,
    BK_TMVRD,
    BK_TMVWR,
    BK_DRD,
    BK_DDIV,
    BK_DOUT,
    BK_RESP
  } back_state_e;
endpackage
`default_nettype wire

@@ design/ppe_chan_if.sv @@
// Valid/ready channel interfaces used on the engine ports.
// Depends on nothing.
`default_nettype none
interface ppe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [23:0] pos_x;
  logic [23:0] pos_y;
  logic [23:0] vel_x;
  logic [23:0] vel_y;
  logic [23:0] gravity;
  logic [15:0] lifetime;
  logic [15:0] start_size;
  logic [23:0] color_start;
  logic [23:0] color_end;
  logic [15:0] delta_time;
  logic [8:0]  slot;
  modport source (output valid, cmd, pos_x, pos_y, vel_x, vel_y, gravity, lifetime,
                  start_size, color_start, color_end, delta_time, slot, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, vel_x, vel_y, gravity, lifetime,
                start_size, color_start, color_end, delta_time, slot, output ready);
endinterface

interface ppe_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  live_count;
  logic [16:0] rect_x;
  logic [16:0] rect_y;
  logic [7:0]  rect_size;
  logic [23:0] rect_color;
  modport source (output valid, status, live_count, rect_x, rect_y, rect_size,
                  rect_color, input ready);
  modport sink (input valid, status, live_count, rect_x, rect_y, rect_size,
                rect_color, output ready);
endinterface
`default_nettype wire

@@ design/ppe_front.sv @@
// Front part: takes input transfers and queues decoded commands.
// Depends on ppe_pkg and ppe_chan_if.
`default_nettype none
module ppe_front
  import ppe_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ppe_in_if.sink    in_i,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o,
  input  wire logic cmd_pop_i
);
  // two-entry queue
  cmd_t       buf_q [2];
  logic       rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_q];

  always_comb begin
    rd_d  = rd_q ^ cmd_pop_i;
    wr_d  = wr_q ^ push;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= '{cmd: cmd_e'(in_i.cmd), pos_x: in_i.pos_x, pos_y: in_i.pos_y,
                       vel_x: in_i.vel_x, vel_y: in_i.vel_y, gravity: in_i.gravity,
                       lifetime: in_i.lifetime, start_size: in_i.start_size,
                       color_start: in_i.color_start, color_end: in_i.color_end,
                       delta_time: in_i.delta_time, slot: in_i.slot};
    end
  end
endmodule
`default_nettype wire

@@ design/ppe_divider.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module ppe_divider #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [NumW-1:0]      quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  assign trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
  assign diff   = trial - {1'b0, den_q};
  assign quo_o  = quo_q;
  assign done_o = busy_q && (cnt_q == CntW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(NumW);
    end else if (busy_q && cnt_q != CntW'(0)) begin
      cnt_q <= cnt_q - CntW'(1);
    end else begin
      busy_q <= 1'b0;
    end
  end

  // shift in one numerator bit and subtract when it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q && cnt_q != CntW'(0)) begin
      if (!diff[DenW]) begin
        rem_q <= diff;
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

@@ design/ppe_back.sv @@
// Back part: pool memory, tick walk, emit and draw arithmetic, result register.
// Depends on ppe_pkg, ppe_divider and ppe_chan_if.
`default_nettype none
module ppe_back
  import ppe_pkg::*;
#(
  parameter int unsigned PoolSize = PoolSizeDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cmd_t      cmd_i,
  input  wire logic cmd_valid_i,
  output logic      cmd_pop_o,
  ppe_out_if.source out_o
);
  localparam int unsigned AddrW = (PoolSize > 1) ? $clog2(PoolSize) : 1;
  localparam int unsigned CntW  = $clog2(PoolSize + 1);

  typedef struct packed {
    logic [23:0] x, y, vx, vy, grav;
    logic [15:0] age, life, size;
    logic [23:0] ca, cb;
  } entry_t;

  // pool memory: one write port, one registered read port
  entry_t      mem [PoolSize];
  entry_t      rd_q;
  logic [AddrW-1:0] raddr, waddr;
  logic        we;
  entry_t      wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  back_state_e st_q, st_d;
  cmd_t        c_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  entry_t      e_q, e_d;
  logic signed [40:0] p0_q, p1_q, p2_q;
  logic [1:0]  ch_q, ch_d;
  logic [23:0] col_q, col_d;
  logic [7:0]  sz_q, sz_d;
  logic        neg_q, neg_d;
  logic [7:0]  c0_q, c0_d;
  logic        ov_q;
  logic        out_v_q;
  logic [1:0]  o_st_q, o_st_d;
  logic [16:0] o_x_q, o_y_q, o_x_d, o_y_d;
  logic [7:0]  o_sz_q, o_sz_d;
  logic [23:0] o_col_q, o_col_d;
  logic        resp_load;

  // divider shared by the three color channels and the side
  logic        div_start, div_done;
  logic [39:0] div_num, div_quo;
  logic [31:0] div_den;
  ppe_divider #(.NumW(40), .DenW(32)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo));

  // saturating base + floor(p/4096)
  function automatic logic [23:0] sat_step(logic [23:0] b, logic signed [40:0] p);
    logic signed [29:0] s;
    s = 30'(signed'(b)) + 30'(p >>> 12);
    if (s > 30'sd8388607) return 24'h7fffff;
    if (s < -30'sd8388608) return 24'h800000;
    return s[23:0];
  endfunction

  function automatic logic [16:0] trunc_pos(logic [23:0] v, logic [7:0] sz);
    logic signed [16:0] t;
    t = 17'(signed'(v[23:8]));
    if (v[23] && v[7:0] != 8'd0) t = t + 17'sd1;
    return t - 17'({1'b0, sz[7:1]});
  endfunction

  logic [16:0] age_sum;
  logic [15:0] age_eff;
  logic [7:0]  ca_ch, cb_ch;
  assign age_eff = (e_q.age > e_q.life) ? e_q.life : e_q.age;
  always_comb begin
    unique case (ch_q)
      2'd0:    begin ca_ch = e_q.ca[23:16]; cb_ch = e_q.cb[23:16]; end
      2'd1:    begin ca_ch = e_q.ca[15:8];  cb_ch = e_q.cb[15:8];  end
      default: begin ca_ch = e_q.ca[7:0];   cb_ch = e_q.cb[7:0];   end
    endcase
  end
  assign age_sum = {1'b0, e_q.age} + {1'b0, c_q.delta_time};

  logic [15:0] life_nz;
  assign life_nz = (e_q.life == 16'd0) ? 16'd1 : e_q.life;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: if (cmd_valid_i) begin
        unique case (cmd_i.cmd)
          CMD_CLEAR: st_d = BK_RESP;
          CMD_EMIT:  st_d = BK_EMIT;
          CMD_TICK:  st_d = BK_TRD;
          default:   st_d = BK_DRD;
        endcase
      end
      BK_EMIT:  st_d = BK_RESP;
      BK_TRD:   st_d = (idx_q >= cnt_q) ? BK_RESP : BK_TAGE;
      BK_TAGE:  st_d = (age_sum[16] || age_sum[15:0] >= e_q.life) ? BK_TMVRD : BK_TMUL;
      BK_TMUL:  st_d = BK_TVY;
      BK_TVY:   st_d = BK_TSUM;
      BK_TSUM:  st_d = BK_TRD;
      BK_TMVRD: st_d = BK_TMVWR;
      // the moved entry is aged in the same slot right away
      BK_TMVWR: st_d = (idx_q >= cnt_q) ? BK_RESP : BK_TAGE;
      BK_DRD:   st_d = ov_q ? BK_RESP : BK_DDIV;
      BK_DDIV:  if (div_done && ch_q == 2'd3) st_d = BK_DOUT;
      BK_DOUT:  st_d = BK_RESP;
      BK_RESP:  if (!out_v_q || out_o.ready) st_d = BK_IDLE;
      default:  st_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    cnt_d = cnt_q; idx_d = idx_q; e_d = e_q;
    ch_d = ch_q; col_d = col_q; sz_d = sz_q; neg_d = neg_q; c0_d = c0_q;
    raddr = idx_q[AddrW-1:0]; waddr = idx_q[AddrW-1:0]; we = 1'b0; wdata = e_q;
    div_start = 1'b0; div_num = '0; div_den = '0;
    o_st_d = o_st_q; o_x_d = o_x_q; o_y_d = o_y_q; o_sz_d = o_sz_q; o_col_d = o_col_q;
    resp_load = 1'b0;
    unique case (st_q)
      BK_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        idx_d = '0;
        o_st_d = ST_DONE; o_x_d = '0; o_y_d = '0; o_sz_d = '0; o_col_d = '0;
        if (cmd_valid_i) begin
          if (cmd_i.cmd == CMD_CLEAR) cnt_d = '0;
          if (cmd_i.cmd == CMD_TICK) raddr = '0;
          if (cmd_i.cmd == CMD_DRAW) raddr = AddrW'(cmd_i.slot);
        end
      end
      BK_EMIT: begin
        if (cnt_q >= CntW'(PoolSize) || c_q.lifetime == 16'd0) begin
          o_st_d = ST_REJECTED;
        end else begin
          we = 1'b1; waddr = cnt_q[AddrW-1:0];
          wdata = '{x: c_q.pos_x, y: c_q.pos_y, vx: c_q.vel_x, vy: c_q.vel_y,
                    grav: c_q.gravity, age: 16'd0, life: c_q.lifetime,
                    size: c_q.start_size, ca: c_q.color_start, cb: c_q.color_end};
          cnt_d = cnt_q + CntW'(1);
        end
      end
      BK_TRD: e_d = rd_q;
      BK_TAGE: begin
        e_d.age = age_sum[16] ? 16'hffff : age_sum[15:0];
        raddr = AddrW'(cnt_q - CntW'(1));
      end
      BK_TMUL: ;
      BK_TVY:  e_d.vy = sat_step(e_q.vy, p0_q);
      BK_TSUM: begin
        e_d.x = sat_step(e_q.x, p1_q);
        e_d.y = sat_step(e_q.y, p2_q);
        we = 1'b1; wdata = e_d;
        idx_d = idx_q + CntW'(1);
        raddr = AddrW'(idx_q + CntW'(1));
      end
      BK_TMVRD: begin
        cnt_d = cnt_q - CntW'(1);
        raddr = AddrW'(cnt_q - CntW'(1));
      end
      BK_TMVWR: begin
        we = 1'b1; wdata = rd_q;
        e_d = rd_q;
      end
      BK_DRD: begin
        e_d = rd_q; ch_d = 2'd0;
        if (ov_q) o_st_d = ST_NOT_LIVE;
        else begin
          div_start = 1'b1;
          div_num = 40'(rd_q.size) * 40'(20 * 32'(rd_q.life == 16'd0 ? 16'd1 : rd_q.life)
                    - 11 * 32'((rd_q.age > rd_q.life) ? rd_q.life : rd_q.age));
          div_den = 32'(rd_q.life == 16'd0 ? 16'd1 : rd_q.life) * 32'd5120;
          ch_d = 2'd0;
        end
      end
      BK_DDIV: if (div_done) begin
        if (ch_q == 2'd0) sz_d = (div_quo == '0) ? 8'd1 :
                                 (div_quo > 40'd255) ? 8'd255 : div_quo[7:0];
        else col_d = {col_q[15:0], neg_q ? c0_q - div_quo[7:0] : c0_q + div_quo[7:0]};
        if (ch_q != 2'd3) begin
          // next channel: |cb - ca| * age / life
          neg_d = ca_ch > cb_ch;
          c0_d = ca_ch;
          div_start = 1'b1;
          div_den = 32'(life_nz);
          div_num = 40'((ca_ch > cb_ch) ? ca_ch - cb_ch : cb_ch - ca_ch) * 40'(age_eff);
          ch_d = ch_q + 2'd1;
        end
      end
      BK_DOUT: begin
        o_sz_d = sz_q; o_col_d = col_q;
        o_x_d = trunc_pos(e_q.x, sz_q);
        o_y_d = trunc_pos(e_q.y, sz_q);
      end
      BK_RESP: resp_load = !out_v_q || out_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; cnt_q <= '0; idx_q <= '0; out_v_q <= 1'b0; ch_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; idx_q <= idx_d; ch_q <= ch_d;
      if (resp_load) out_v_q <= 1'b1;
      else if (out_o.ready) out_v_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      c_q  <= cmd_i;
      ov_q <= (32'(cmd_i.slot) >= 32'(cnt_q)) || (32'(cmd_i.slot) >= PoolSize);
    end
    e_q <= e_d; col_q <= col_d; sz_q <= sz_d; neg_q <= neg_d; c0_q <= c0_d;
    o_st_q <= o_st_d; o_x_q <= o_x_d; o_y_q <= o_y_d; o_sz_q <= o_sz_d;
    o_col_q <= o_col_d;
    p0_q <= signed'(e_q.grav) * signed'({1'b0, c_q.delta_time});
    p1_q <= signed'(e_q.vx) * signed'({1'b0, c_q.delta_time});
    p2_q <= signed'(e_d.vy) * signed'({1'b0, c_q.delta_time});
    if (resp_load) begin
      out_o.status     <= o_st_q;
      out_o.live_count <= 10'(cnt_q);
      out_o.rect_x     <= o_x_q;
      out_o.rect_y     <= o_y_q;
      out_o.rect_size  <= o_sz_q;
      out_o.rect_color <= o_col_q;
    end
  end
  assign out_o.valid = out_v_q;
endmodule
`default_nettype wire

@@ design/particle_pool_engine.sv @@
// Top level of the particle pool engine: front queue plus back executor.
// Depends on ppe_pkg, ppe_chan_if, ppe_front and ppe_back.
//
//  channel  dir   handshake     payload
//  in_i     in    valid/ready   cmd and emit/tick/draw fields
//  out_o    out   valid/ready   status, live_count, rect fields
//
// A draw of a live slot runs the bit-serial divider four times, once for the size
// and once per color channel; a draw of a dead slot skips the divider.
// Tick walks the live particles through the single read port; a removed particle
// is replaced by the last entry, which is then aged in the same slot.
// Reset is asynchronous and empties the pool; memory contents are not cleared.
// The front queue holds two commands, so input is still taken while a result stalls, until it fills.
`default_nettype none
module particle_pool_engine
  import ppe_pkg::*;
#(
  parameter int unsigned PoolSize = PoolSizeDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ppe_in_if.sink    in_i,
  ppe_out_if.source out_o
);
  cmd_t q_cmd;
  logic q_valid, q_pop;

  ppe_front u_front (
    .clk_i, .rst_ni, .in_i, .cmd_o(q_cmd), .cmd_valid_o(q_valid), .cmd_pop_i(q_pop));

  ppe_back #(.PoolSize(PoolSize)) u_back (
    .clk_i, .rst_ni, .cmd_i(q_cmd), .cmd_valid_i(q_valid), .cmd_pop_o(q_pop), .out_o);
endmodule
`default_nettype wire

@@ design/ppe_checker.sv @@
// Port-level checker for the particle pool engine, bound to the top level.
// Depends on particle_pool_engine_assert.svh.
`default_nettype none
`include "particle_pool_engine_assert.svh"
module ppe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [9:0]  live_count,
  input wire logic [7:0]  rect_size
);
  `PPE_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `PPE_ASSERT_IMP(a_cnt, clk_i, rst_ni, out_valid, live_count <= 10'd512)
  `PPE_ASSERT_IMP(a_bad, clk_i, rst_ni, out_valid && status == 2'd2, rect_size == 8'd0)
endmodule

bind particle_pool_engine ppe_checker u_chk (
  .clk_i, .rst_ni, .out_valid(out_o.valid), .out_ready(out_o.ready),
  .status(out_o.status), .live_count(out_o.live_count), .rect_size(out_o.rect_size));
`default_nettype wire

@@ tb/sv/particle_pool_engine_tb.sv @@
// Testbench of the particle pool engine: directed and random command streams,
// checked against a behavioral model of the pool. Uses ppe_pkg and ppe_chan_if.
`timescale 1ns / 1ps
`default_nettype none
module particle_pool_engine_tb
  import ppe_pkg::*;
();

  localparam int unsigned PoolSize = 512;
  localparam int unsigned StallLimit = 200000;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  live_count;
    logic [16:0] rect_x;
    logic [16:0] rect_y;
    logic [7:0]  rect_size;
    logic [23:0] rect_color;
  } draw_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppe_in_if  cmd_ch ();
  ppe_out_if res_ch ();

  particle_pool_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch.sink),
    .out_o  (res_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // pool model state
  int          pool_x[PoolSize];
  int          pool_y[PoolSize];
  int          pool_vx[PoolSize];
  int          pool_vy[PoolSize];
  int          pool_grav[PoolSize];
  int unsigned pool_age[PoolSize];
  int unsigned pool_life[PoolSize];
  int unsigned pool_size[PoolSize];
  int unsigned pool_ca[PoolSize];
  int unsigned pool_cb[PoolSize];
  int unsigned pool_live;

  draw_result_t expected_q[$];
  int          send_idle_pct;
  int          sink_stall_pct;
  int          mismatches;
  int          results_seen;
  int          items_sent;
  int          idle_cycles;
  int unsigned cmd_hist[4];
  bit          timed_out;

  // v + floor(rate*dt/4096), clamped to 24-bit signed
  function automatic int euler_step(int v, int rate, int unsigned dt);
    longint p;
    longint s;
    p = longint'(rate) * longint'(dt);
    s = longint'(v) + (p >>> 12);
    if (s > 64'sd8388607) s = 8388607;
    if (s < -64'sd8388608) s = -8388608;
    return int'(s);
  endfunction

  function automatic int unsigned fade_chan(int unsigned c0, int unsigned c1,
                                            int unsigned age, int unsigned life);
    if (c1 >= c0) return c0 + int'((longint'(c1 - c0) * age) / life);
    return c0 - int'((longint'(c0 - c1) * age) / life);
  endfunction

  function automatic int pix_trunc(int v);
    return (v >= 0) ? v / 256 : -((-v) / 256);
  endfunction

  function automatic int sx24(logic [23:0] v);
    return int'(signed'(v));
  endfunction

  function automatic void pool_move(int unsigned d, int unsigned s);
    pool_x[d] = pool_x[s];     pool_y[d] = pool_y[s];
    pool_vx[d] = pool_vx[s];   pool_vy[d] = pool_vy[s];
    pool_grav[d] = pool_grav[s];
    pool_age[d] = pool_age[s]; pool_life[d] = pool_life[s];
    pool_size[d] = pool_size[s];
    pool_ca[d] = pool_ca[s];   pool_cb[d] = pool_cb[s];
  endfunction

  // applies one command to the pool model and returns its result
  function automatic draw_result_t pool_apply(cmd_t c);
    draw_result_t r;
    int unsigned i, a, s, age, life, rs, rr, gg, bb;
    longint unsigned num, den;
    r = '0;
    r.status = ST_DONE;
    case (c.cmd)
      CMD_CLEAR: pool_live = 0;
      CMD_EMIT: begin
        if (pool_live >= PoolSize || c.lifetime == 0) begin
          r.status = ST_REJECTED;
        end else begin
          i = pool_live;
          pool_x[i] = sx24(c.pos_x);   pool_y[i] = sx24(c.pos_y);
          pool_vx[i] = sx24(c.vel_x);  pool_vy[i] = sx24(c.vel_y);
          pool_grav[i] = sx24(c.gravity);
          pool_age[i] = 0;             pool_life[i] = c.lifetime;
          pool_size[i] = c.start_size;
          pool_ca[i] = c.color_start;  pool_cb[i] = c.color_end;
          pool_live = i + 1;
        end
      end
      CMD_TICK: begin
        i = 0;
        while (i < pool_live) begin
          a = pool_age[i] + c.delta_time;
          if (a > 16'hFFFF) a = 16'hFFFF;
          pool_age[i] = a;
          if (a >= pool_life[i]) begin
            pool_live--;
            pool_move(i, pool_live);
          end else begin
            pool_vy[i] = euler_step(pool_vy[i], pool_grav[i], c.delta_time);
            pool_x[i] = euler_step(pool_x[i], pool_vx[i], c.delta_time);
            pool_y[i] = euler_step(pool_y[i], pool_vy[i], c.delta_time);
            i++;
          end
        end
      end
      default: begin
        s = c.slot;
        if (s >= pool_live) begin
          r.status = ST_NOT_LIVE;
        end else begin
          age = pool_age[s];
          life = (pool_life[s] == 0) ? 1 : pool_life[s];
          if (age > life) age = life;
          rr = fade_chan((pool_ca[s] >> 16) & 8'hFF, (pool_cb[s] >> 16) & 8'hFF, age, life);
          gg = fade_chan((pool_ca[s] >> 8) & 8'hFF, (pool_cb[s] >> 8) & 8'hFF, age, life);
          bb = fade_chan(pool_ca[s] & 8'hFF, pool_cb[s] & 8'hFF, age, life);
          r.rect_color = {rr[7:0], gg[7:0], bb[7:0]};
          num = longint'(pool_size[s]) * (20 * longint'(life) - 11 * longint'(age));
          den = 20 * longint'(life) * 256;
          rs = int'(num / den);
          if (rs < 1) rs = 1;
          if (rs > 255) rs = 255;
          r.rect_size = rs[7:0];
          r.rect_x = 17'(pix_trunc(pool_x[s]) - int'(rs / 2));
          r.rect_y = 17'(pix_trunc(pool_y[s]) - int'(rs / 2));
        end
      end
    endcase
    r.live_count = pool_live[9:0];
    return r;
  endfunction

  // one transfer on the command channel; valid drops only while the sender idles
  task automatic send_cmd(cmd_t c);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.cmd         <= c.cmd;
    cmd_ch.pos_x       <= c.pos_x;
    cmd_ch.pos_y       <= c.pos_y;
    cmd_ch.vel_x       <= c.vel_x;
    cmd_ch.vel_y       <= c.vel_y;
    cmd_ch.gravity     <= c.gravity;
    cmd_ch.lifetime    <= c.lifetime;
    cmd_ch.start_size  <= c.start_size;
    cmd_ch.color_start <= c.color_start;
    cmd_ch.color_end   <= c.color_end;
    cmd_ch.delta_time  <= c.delta_time;
    cmd_ch.slot        <= c.slot;
    do @(posedge clk_i); while (!cmd_ch.ready);
    expected_q.push_back(pool_apply(c));
    cmd_hist[c.cmd]++;
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic cmd_t rand_emit();
    cmd_t c;
    c = '0;
    c.cmd = CMD_EMIT;
    c.pos_x = 24'($urandom);       c.pos_y = 24'($urandom);
    c.vel_x = 24'($urandom);       c.vel_y = 24'($urandom);
    c.gravity = 24'($urandom);
    c.lifetime = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(8000, 1));
    c.start_size = 16'($urandom);
    c.color_start = 24'($urandom); c.color_end = 24'($urandom);
    c.delta_time = 16'($urandom);  c.slot = 9'($urandom);
    return c;
  endfunction

  function automatic cmd_t mk_cmd(cmd_e op, int unsigned dt, int unsigned slot_i);
    cmd_t c;
    c = rand_emit();
    c.cmd = op;
    c.delta_time = dt[15:0];
    c.slot = slot_i[8:0];
    return c;
  endfunction

  // extremes of every emit field, zero lifetime, draws at both ends of the pool
  task automatic test_directed();
    cmd_t c;
    send_cmd(mk_cmd(CMD_DRAW, 0, 0));
    send_cmd(mk_cmd(CMD_TICK, 100, 0));
    c = rand_emit();
    c.pos_x = 24'h7FFFFF; c.pos_y = 24'h800000; c.vel_x = 24'h7FFFFF;
    c.vel_y = 24'h800000; c.gravity = 24'h800000; c.lifetime = 16'hFFFF;
    c.start_size = 16'hFFFF; c.color_start = 24'h000000; c.color_end = 24'hFFFFFF;
    send_cmd(c);
    c = rand_emit();
    c.pos_x = 24'h800000; c.pos_y = 24'h7FFFFF; c.vel_x = 24'h800000;
    c.vel_y = 24'h7FFFFF; c.gravity = 24'h7FFFFF; c.lifetime = 16'd1;
    c.start_size = 16'd0; c.color_start = 24'hFFFFFF; c.color_end = 24'h000000;
    send_cmd(c);
    c = rand_emit();
    c.lifetime = 16'd0;
    send_cmd(c);
    send_cmd(mk_cmd(CMD_DRAW, 0, 0));
    send_cmd(mk_cmd(CMD_DRAW, 0, 1));
    send_cmd(mk_cmd(CMD_DRAW, 0, 2));
    send_cmd(mk_cmd(CMD_DRAW, 0, 511));
    send_cmd(mk_cmd(CMD_TICK, 0, 0));
    send_cmd(mk_cmd(CMD_DRAW, 0, 0));
    send_cmd(mk_cmd(CMD_TICK, 4000, 0));
    send_cmd(mk_cmd(CMD_DRAW, 0, 0));
    send_cmd(mk_cmd(CMD_TICK, 16'hFFFF, 0));
    send_cmd(mk_cmd(CMD_DRAW, 0, 0));
    send_cmd(mk_cmd(CMD_CLEAR, 0, 0));
    send_cmd(mk_cmd(CMD_DRAW, 0, 0));
  endtask

  // mixed stream: mostly emits, ticks and draws of live slots
  task automatic test_random(int n);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 3) send_cmd(mk_cmd(CMD_CLEAR, 0, 0));
      else if (k < 45 && pool_live < 24) send_cmd(rand_emit());
      else if (k < 65)
        send_cmd(mk_cmd(CMD_TICK, ($urandom_range(15) == 0) ? $urandom : $urandom_range(600),
                        0));
      else
        send_cmd(mk_cmd(CMD_DRAW, 0, ($urandom_range(9) == 0 || pool_live == 0) ?
                        $urandom_range(511) : $urandom_range(pool_live - 1)));
    end
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int n);
    send_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    test_random(n);
  endtask

  // result checker, ready toggled at the falling edge
  always @(negedge clk_i) begin
    res_ch.ready <= !(sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin
    draw_result_t got, want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = {res_ch.status, res_ch.live_count, res_ch.rect_x, res_ch.rect_y,
             res_ch.rect_size, res_ch.rect_color};
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: exp st=%0d n=%0d x=%0d y=%0d sz=%0d c=%h",
                     results_seen, want.status, want.live_count, $signed(want.rect_x),
                     $signed(want.rect_y), want.rect_size, want.rect_color);
            $display("result %0d: got st=%0d n=%0d x=%0d y=%0d sz=%0d c=%h",
                     results_seen, got.status, got.live_count, $signed(got.rect_x),
                     $signed(got.rect_y), got.rect_size, got.rect_color);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) timed_out <= 1'b1;
  end

  initial begin
    mismatches = 0; results_seen = 0; items_sent = 0; idle_cycles = 0;
    timed_out = 1'b0; pool_live = 0; send_idle_pct = 0; sink_stall_pct = 0;
    cmd_hist = '{default: 0};
    cmd_ch.valid = 1'b0; cmd_ch.cmd = CMD_CLEAR;
    cmd_ch.pos_x = '0; cmd_ch.pos_y = '0; cmd_ch.vel_x = '0; cmd_ch.vel_y = '0;
    cmd_ch.gravity = '0; cmd_ch.lifetime = '0; cmd_ch.start_size = '0;
    cmd_ch.color_start = '0; cmd_ch.color_end = '0; cmd_ch.delta_time = '0;
    cmd_ch.slot = '0; res_ch.ready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    run_phase(0, 0, 100);
    run_phase(61, 0, 100);
    run_phase(0, 61, 100);
    run_phase(15, 15, 100);
    cmd_ch.valid <= 1'b0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    while (expected_q.size() != 0 && !timed_out) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    $display("%0d commands (clear %0d, emit %0d, tick %0d, draw %0d), %0d results checked",
             items_sent, cmd_hist[0], cmd_hist[1], cmd_hist[2], cmd_hist[3], results_seen);
    $display("covered field extremes, dead slots, expiry and sender/receiver stalls");
    if (!timed_out && mismatches == 0 && expected_q.size() == 0) begin
      $display("** particle_pool_engine: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("** particle_pool_engine: FAILED **");
    end
    $finish;
  end

  // abort on a stuck handshake
  initial begin
    wait (timed_out);
    $display("watchdog expired with %0d results pending", expected_q.size());
    $display("** particle_pool_engine: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
